// ===== rtl/core/max_heap_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Max-heap priority queue assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication
`define MPH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MPH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mph_pkg.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Payload types, status and function codes, and sequencer states.
// ----------------------------------------------------------------------------
package mph_pkg;

    localparam int HEAP_DEPTH_DEF = 256;
    localparam int KEY_W          = 32;
    localparam int COUNT_W        = 8;

    localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

    typedef enum logic {
        FN_PUSH = 1'b0,
        FN_POP  = 1'b1
    } mph_func_t;

    typedef enum logic [1:0] {
        ST_PUSHED   = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } mph_status_t;

    typedef struct packed {
        mph_func_t               func;
        logic signed [KEY_W-1:0] key_in;
    } mph_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        mph_status_t             status;
        logic [COUNT_W-1:0]      count;
    } mph_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_RD,
        S_P_CMP,
        S_Q_TOP,
        S_Q_LAST,
        S_Q_GETLAST,
        S_Q_CHK,
        S_Q_RDR,
        S_Q_SEL,
        S_Q_CMP,
        S_DONE
    } mph_state_t;

endpackage

// ===== rtl/core/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap of signed 32-bit keys with push and pop-maximum operations.
// ----------------------------------------------------------------------------
//  Channel | Ports                      | Carries
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data   | func, key_in (mph_in_t)
//  result  | m_valid, m_ready, m_data   | key_out, status, count (mph_out_t)
//
//  A push climbs until the parent is not smaller or the root is reached; a pop
//  sinks until no child is larger or none is left. Either moves up to
//  log2(HEAP_DEPTH) - 1 levels, one at a time over the single store read port
//  and the one comparator. Full pushes and empty pops go straight to the result.
//  Reset clears state, entry count and output valid; the store needs no clearing.
//  A new transaction is taken while a result waits in m_data; the next holds.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
    import mph_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mph_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output mph_out_t m_data
);

    localparam int AW = $clog2(HEAP_DEPTH);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    logic             res_valid;
    logic             res_ready;
    mph_out_t         res_data;

    logic             m_valid_reg;
    mph_out_t         m_data_reg;

    mph_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW),
        .DW    (KEY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mph_seq #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Free the output register when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/mph_ram.sv =====
// ----------------------------------------------------------------------------
// Heap key store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mph_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write the selected slot
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mph_seq.sv =====
// ----------------------------------------------------------------------------
// Heap sequencer
// Runs sift-up and sift-down over the key store with one shared comparator.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_defines.svh"

module mph_seq
    import mph_pkg::*;
#(
    parameter int DEPTH = HEAP_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mph_in_t          in_data,
    output logic             res_valid,
    input  logic             res_ready,
    output mph_out_t         res_data,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [KEY_W-1:0] ram_wdata,
    output logic [AW-1:0]    ram_raddr,
    input  logic [KEY_W-1:0] ram_rdata
);

    localparam logic [AW-1:0] CNT_MAX = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROOT    = AW'(1);

    mph_state_t        state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     kid_idx_reg, kid_idx_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  kid_reg, kid_next;
    logic [KEY_W-1:0]  top_reg, top_next;
    mph_status_t       status_reg, status_next;

    logic [AW:0]       left_idx, right_idx;
    logic              left_ok, right_ok;
    logic [KEY_W-1:0]  cmp_a, cmp_b;
    logic              cmp_gt;

    // Child indexes and their bounds against the live count
    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = {pos_reg, 1'b1};
    assign left_ok   = ({1'b0, cnt_reg} >= left_idx);
    assign right_ok  = ({1'b0, cnt_reg} >= right_idx);

    // Shared signed comparator, operands picked by state
    always_comb begin
        case (state_reg)
            S_P_CMP: begin
                cmp_a = key_reg;
                cmp_b = ram_rdata;
            end
            S_Q_SEL: begin
                cmp_a = ram_rdata;
                cmp_b = kid_reg;
            end
            default: begin
                cmp_a = kid_reg;
                cmp_b = key_reg;
            end
        endcase
    end
    assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_data.func == FN_PUSH) begin
                        state_next = (cnt_reg == CNT_MAX) ? S_DONE : S_P_RD;
                    end else begin
                        state_next = (cnt_reg == '0) ? S_DONE : S_Q_TOP;
                    end
                end
            end
            S_P_RD:      state_next = (pos_reg == ROOT) ? S_DONE : S_P_CMP;
            S_P_CMP:     state_next = cmp_gt ? S_P_RD : S_DONE;
            S_Q_TOP:     state_next = S_Q_LAST;
            S_Q_LAST:    state_next = S_Q_GETLAST;
            S_Q_GETLAST: state_next = S_Q_CHK;
            S_Q_CHK:     state_next = left_ok ? S_Q_RDR : S_DONE;
            S_Q_RDR:     state_next = S_Q_SEL;
            S_Q_SEL:     state_next = S_Q_CMP;
            S_Q_CMP:     state_next = cmp_gt ? S_Q_CHK : S_DONE;
            S_DONE:      state_next = res_ready ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs: handshake, store access and result
    always_comb begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_DONE);
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = key_reg;
        ram_raddr = pos_reg;
        case (state_reg)
            S_P_RD: begin
                ram_raddr = pos_reg >> 1;
                ram_we    = (pos_reg == ROOT);
            end
            S_P_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = cmp_gt ? ram_rdata : key_reg;
            end
            S_Q_TOP:  ram_raddr = ROOT;
            S_Q_LAST: ram_raddr = cnt_reg;
            S_Q_CHK: begin
                ram_raddr = left_idx[AW-1:0];
                ram_we    = !left_ok;
            end
            S_Q_RDR:  ram_raddr = right_idx[AW-1:0];
            S_Q_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = cmp_gt ? kid_reg : key_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        res_data.status = status_reg;
        res_data.count  = COUNT_W'(cnt_reg);
        case (status_reg)
            ST_POPPED: res_data.key_out = top_reg;
            ST_EMPTY:  res_data.key_out = EMPTY_KEY;
            default:   res_data.key_out = '0;
        endcase
    end

    // Datapath next values
    always_comb begin
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        kid_idx_next = kid_idx_reg;
        key_next     = key_reg;
        kid_next     = kid_reg;
        top_next     = top_reg;
        status_next  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    key_next = in_data.key_in;
                    if (in_data.func == FN_PUSH) begin
                        if (cnt_reg == CNT_MAX) begin
                            status_next = ST_OVERFLOW;
                        end else begin
                            status_next = ST_PUSHED;
                            cnt_next    = cnt_reg + 1'b1;
                            pos_next    = cnt_reg + 1'b1;
                        end
                    end else begin
                        status_next = (cnt_reg == '0) ? ST_EMPTY : ST_POPPED;
                    end
                end
            end
            S_P_CMP: begin
                if (cmp_gt) begin
                    pos_next = pos_reg >> 1;
                end
            end
            S_Q_LAST: top_next = ram_rdata;
            S_Q_GETLAST: begin
                key_next = ram_rdata;
                cnt_next = cnt_reg - 1'b1;
                pos_next = ROOT;
            end
            S_Q_RDR: begin
                kid_next     = ram_rdata;
                kid_idx_next = left_idx[AW-1:0];
            end
            S_Q_SEL: begin
                if (right_ok && cmp_gt) begin
                    kid_next     = ram_rdata;
                    kid_idx_next = right_idx[AW-1:0];
                end
            end
            S_Q_CMP: begin
                if (cmp_gt) begin
                    pos_next = kid_idx_reg;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        kid_idx_reg <= kid_idx_next;
        key_reg     <= key_next;
        kid_reg     <= kid_next;
        top_reg     <= top_next;
        status_reg  <= status_next;
    end

    `MPH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX, "entry count above capacity")
    `MPH_ASSERT_NOW(a_no_slot0, ram_we, ram_waddr != '0, "write to unused slot zero")
    `MPH_ASSERT_NEXT(a_push_grow,
        in_valid && in_ready && in_data.func == FN_PUSH && cnt_reg != CNT_MAX,
        cnt_reg == $past(cnt_reg) + 1'b1, "push did not grow the heap")
    `MPH_ASSERT_NEXT(a_pop_shrink, state_reg == S_Q_GETLAST,
        cnt_reg == $past(cnt_reg) - 1'b1, "pop did not shrink the heap")

endmodule

// ===== sim/max_heap_priority_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Watches both channels, keeps its own heap image, predicts one result per
// accepted transaction and compares every returned result in order.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_checker
    import mph_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  mph_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  mph_out_t m_data,
    output int       n_pending,
    output int       n_errors,
    output int       n_pushed,
    output int       n_overflow,
    output int       n_popped,
    output int       n_empty
);

    // Heap image, one-based, slot 0 unused
    logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
    int                      img_count;
    mph_out_t                heap_results_q [$];
    int                      err_cnt;
    int                      cnt_push, cnt_ovf, cnt_pop, cnt_empty;

    // Apply one operation to the heap image and return the result it yields
    function automatic mph_out_t heap_apply(input mph_in_t op);
        mph_out_t                res;
        int                      pos;
        int                      kid;
        logic signed [KEY_W-1:0] top_key;
        logic signed [KEY_W-1:0] last_key;
        res = '0;
        if (op.func == FN_PUSH) begin
            res.key_out = '0;
            if (img_count >= HEAP_DEPTH - 1) begin
                res.status = ST_OVERFLOW;
            end else begin
                img_count++;
                pos = img_count;
                // Climb while strictly greater than the parent
                while (pos > 1 && op.key_in > heap_keys[pos >> 1]) begin
                    heap_keys[pos] = heap_keys[pos >> 1];
                    pos = pos >> 1;
                end
                heap_keys[pos] = op.key_in;
                res.status = ST_PUSHED;
            end
        end else begin
            if (img_count == 0) begin
                res.key_out = EMPTY_KEY;
                res.status  = ST_EMPTY;
            end else begin
                top_key  = heap_keys[1];
                last_key = heap_keys[img_count];
                img_count--;
                pos = 1;
                // Sink the moved entry past the larger child, left on a tie
                while (2 * pos <= img_count) begin
                    kid = 2 * pos;
                    if (kid + 1 <= img_count && heap_keys[kid + 1] > heap_keys[kid])
                        kid++;
                    if (!(heap_keys[kid] > last_key))
                        break;
                    heap_keys[pos] = heap_keys[kid];
                    pos = kid;
                end
                heap_keys[pos] = last_key;
                res.key_out = top_key;
                res.status  = ST_POPPED;
            end
        end
        res.count = img_count[COUNT_W-1:0];
        return res;
    endfunction

    // Compare results, then record new transactions
    always @(posedge aclk) begin
        mph_out_t want;
        mph_out_t pred;
        if (!aresetn) begin
            img_count = 0;
            heap_results_q.delete();
            err_cnt   = 0;
            cnt_push  = 0;
            cnt_ovf   = 0;
            cnt_pop   = 0;
            cnt_empty = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (heap_results_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result key_out=%0d status=%0d count=%0d",
                             $time, m_data.key_out, m_data.status, m_data.count);
                end else begin
                    want = heap_results_q.pop_front();
                    if (m_data.key_out !== want.key_out) begin
                        err_cnt++;
                        $display("%0t: key_out mismatch, expected %0d, actual %0d",
                                 $time, want.key_out, m_data.key_out);
                    end
                    if (m_data.status !== want.status) begin
                        err_cnt++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_data.status);
                    end
                    if (m_data.count !== want.count) begin
                        err_cnt++;
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, want.count, m_data.count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred = heap_apply(s_data);
                heap_results_q.push_back(pred);
                case (pred.status)
                    ST_PUSHED:   cnt_push++;
                    ST_OVERFLOW: cnt_ovf++;
                    ST_POPPED:   cnt_pop++;
                    default:     cnt_empty++;
                endcase
            end
        end
        n_pending  <= heap_results_q.size();
        n_errors   <= err_cnt;
        n_pushed   <= cnt_push;
        n_overflow <= cnt_ovf;
        n_popped   <= cnt_pop;
        n_empty    <= cnt_empty;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives push and pop transactions with random idling on both channels:
// a directed opening, a fill past capacity, a drain past empty and a long
// mixed run. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mph_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_PCT     = 29;

    logic     aclk     = 1'b0;
    logic     aresetn  = 1'b0;
    logic     s_valid  = 1'b0;
    mph_in_t  s_data   = '0;
    logic     m_ready  = 1'b0;
    logic     s_ready;
    logic     m_valid;
    mph_out_t m_data;

    logic     steady_flow = 1'b0;
    int       cycle_count = 0;
    int       n_pending, n_errors, n_pushed, n_overflow, n_popped, n_empty;

    always #2 aclk = ~aclk;

    max_heap_priority_queue u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    max_heap_priority_queue_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .n_pending  (n_pending),
        .n_errors   (n_errors),
        .n_pushed   (n_pushed),
        .n_overflow (n_overflow),
        .n_popped   (n_popped),
        .n_empty    (n_empty)
    );

    // Stall the result channel at random, except during the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, n_pending);
            $display("max_heap_priority_queue verification failed");
            $finish;
        end
    end

    // Offer one transaction; entered and left at a falling edge
    task automatic send_item(input mph_func_t fn, input logic signed [KEY_W-1:0] key);
        if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_data  <= '{func: fn, key_in: key};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold off the sender until every result is back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (n_pending != 0);
    endtask

    // Mix of full-range, extreme, clustered and mid-range keys
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom;
        else if (sel < 70)
            return $signed($urandom_range(0, 7)) - 4;
        else if (sel < 80) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end else
            return $signed($urandom_range(0, 1000)) - 500;
    endfunction

    // Issue a run of transactions with a given share of pushes
    task automatic send_mix(input int n_items, input int push_pct);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < push_pct)
                send_item(FN_PUSH, pick_key());
            else
                send_item(FN_POP, $urandom);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty pop, key extremes, equal keys, alternating bits
        send_item(FN_POP, 32'sh7FFF_FFFF);
        send_item(FN_PUSH, 32'sh7FFF_FFFF);
        send_item(FN_PUSH, 32'sh8000_0000);
        send_item(FN_PUSH, 32'sd0);
        send_item(FN_PUSH, -32'sd1);
        send_item(FN_PUSH, 32'sd5);
        send_item(FN_PUSH, 32'sd5);
        send_item(FN_PUSH, 32'sd5);
        send_item(FN_PUSH, 32'sh8000_0000);
        repeat (4) send_item(FN_POP, 32'sh0);
        send_item(FN_PUSH, 32'sh5555_5555);
        send_item(FN_PUSH, 32'shAAAA_AAAA);
        repeat (7) send_item(FN_POP, $urandom);

        // Let the block go quiet before the random part
        hold_until_drained();

        // Fill well past capacity, then drain well past empty
        send_mix(320, 95);
        hold_until_drained();
        send_mix(320, 5);

        // Mixed traffic in blocks of varying bias, two blocks with no idling
        for (int blk = 0; blk < 12; blk++) begin
            steady_flow <= (blk == 4 || blk == 5);
            case ($urandom_range(0, 2))
                0:       send_mix(100, 30);
                1:       send_mix(100, 50);
                default: send_mix(100, 70);
            endcase
        end
        steady_flow <= 1'b0;
        send_mix(10, 50);

        // Wait out the last results
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d pushes, %0d pushes on a full heap,", n_pushed, n_overflow);
        $display("%0d pops and %0d pops on an empty heap", n_popped, n_empty);
        if (n_errors == 0) begin
            $display("max_heap_priority_queue verification clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("max_heap_priority_queue verification failed");
        end
        $finish;
    end

endmodule
